// ----- rtl/core/pwmf_pkg.sv -----
// shared types and codes for the pwm audio sample feeder
package pwmf_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  localparam logic [2:0] REG_PLAY_MODE   = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [2:0] REG_TONE_LENGTH = 3'd2;
  localparam logic [2:0] REG_DATA_BYTES  = 3'd3;
  localparam logic [2:0] REG_STEREO      = 3'd4;
  localparam logic [2:0] REG_PWM_TOP     = 3'd5;

  localparam logic [15:0] PWM_TOP_RESET = 16'd1023;

  // tone table entries, indexed by a slice of the phase
  localparam int TABLE_DEPTH = 256;

  // where the duty of an item comes from
  typedef enum logic [1:0] {
    SRC_MAP,
    SRC_MID,
    SRC_ZERO,
    SRC_HOLD
  } duty_src_e;

  typedef struct packed {
    logic        play_mode;
    logic [31:0] phase_step;
    logic [31:0] tone_length;
    logic [31:0] data_bytes;
    logic        stereo;
    logic [15:0] pwm_top;
  } cfg_t;

  typedef struct packed {
    duty_src_e   src;
    logic        from_table;
    logic [15:0] sample;
    logic        carrier;
    logic        busy;
    logic        tone_done;
    logic        wave_done;
    logic [31:0] fed;
  } item_t;

endpackage

// ----- rtl/core/pwm_audio_sample_feeder.sv -----
// top level of the pwm audio sample feeder
// Turns tone-table or streamed pcm audio into a pwm compare value, one result per
// input transfer. A new item is taken every cycle unless the output stalls; each result
// passes the input register with the tone table read, multiply register, then divide and
// result register, and a stall on the output backs up through these stages one at a time.
// The tone table holds TABLE_DEPTH entries indexed by phase bits [31:16] modulo the depth;
// an entry must be written before a tone reads it. Registers sit at apb byte addresses
// 4*i; the user must write them only while no playback item is in flight (unenforced).
module pwm_audio_sample_feeder import pwmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] left_sample_i,
  input  logic [15:0] right_sample_i,
  input  logic        left_ok_i,
  input  logic        right_ok_i,
  input  logic        stream_end_i,
  input  logic [7:0]  table_index_i,
  input  logic [15:0] table_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_o,
  output logic        carrier_active_o,
  output logic        busy_res_o,
  output logic        tone_done_o,
  output logic        wave_done_o,
  output logic [31:0] fed_count_o
);

  cfg_t        cfg;
  logic        s1_valid;
  logic        s1_ready;
  item_t       s1_item;
  logic [15:0] table_data;

  pwmf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwmf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .left_ok_i      (left_ok_i),
    .right_ok_i     (right_ok_i),
    .stream_end_i   (stream_end_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .s1_ready_i     (s1_ready),
    .s1_valid_o     (s1_valid),
    .item_o         (s1_item),
    .table_data_o   (table_data)
  );

  pwmf_duty u_duty (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pwm_top_i        (cfg.pwm_top),
    .s1_valid_i       (s1_valid),
    .s1_ready_o       (s1_ready),
    .item_i           (s1_item),
    .table_data_i     (table_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duty_o           (duty_o),
    .carrier_active_o (carrier_active_o),
    .busy_res_o       (busy_res_o),
    .tone_done_o      (tone_done_o),
    .wave_done_o      (wave_done_o),
    .fed_count_o      (fed_count_o)
  );

endmodule

// ----- rtl/core/pwmf_regs.sv -----
// apb configuration registers
module pwmf_regs import pwmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        REG_PLAY_MODE:   cfg_d.play_mode   = pwdata[0];
        REG_PHASE_STEP:  cfg_d.phase_step  = pwdata;
        REG_TONE_LENGTH: cfg_d.tone_length = pwdata;
        REG_DATA_BYTES:  cfg_d.data_bytes  = pwdata;
        REG_STEREO:      cfg_d.stereo      = pwdata[0];
        REG_PWM_TOP:     cfg_d.pwm_top     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PLAY_MODE:   prdata = {31'd0, cfg_q.play_mode};
      REG_PHASE_STEP:  prdata = cfg_q.phase_step;
      REG_TONE_LENGTH: prdata = cfg_q.tone_length;
      REG_DATA_BYTES:  prdata = cfg_q.data_bytes;
      REG_STEREO:      prdata = {31'd0, cfg_q.stereo};
      REG_PWM_TOP:     prdata = {16'd0, cfg_q.pwm_top};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_mode   <= 1'b0;
      cfg_q.phase_step  <= 32'd0;
      cfg_q.tone_length <= 32'd1;
      cfg_q.data_bytes  <= 32'd0;
      cfg_q.stereo      <= 1'b0;
      cfg_q.pwm_top     <= PWM_TOP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/pwmf_ctrl.sv -----
// playback state, tone table and input register stage
module pwmf_ctrl import pwmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] left_sample_i,
  input  logic [15:0] right_sample_i,
  input  logic        left_ok_i,
  input  logic        right_ok_i,
  input  logic        stream_end_i,
  input  logic [7:0]  table_index_i,
  input  logic [15:0] table_value_i,
  input  logic        s1_ready_i,
  output logic        s1_valid_o,
  output item_t       item_o,
  output logic [15:0] table_data_o
);

  // table depth is a power of two, so the index is a bit slice
  localparam int AW = $clog2(TABLE_DEPTH);

  logic [31:0] phase_acc_q, phase_acc_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [31:0] fed_q, fed_d;
  logic        tone_run_q, tone_run_d;
  logic        wave_run_q, wave_run_d;
  logic        carrier_q, carrier_d;
  logic        s1_valid_q;
  item_t       item_q, item_d;

  logic [15:0] table_mem [TABLE_DEPTH];
  logic [15:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic        accept;
  logic [16:0] pair_sum;
  logic [16:0] pair_adj;
  logic [15:0] pair_avg;
  logic [31:0] len_m1;

  assign in_ready_o   = !s1_valid_q || s1_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign s1_valid_o   = s1_valid_q;
  assign item_o       = item_q;
  assign table_data_o = rdata_q;
  assign wr_addr      = AW'(table_index_i);

  // stereo average, truncated toward zero
  assign pair_sum = {left_sample_i[15], left_sample_i} + {right_sample_i[15], right_sample_i};
  assign pair_adj = pair_sum + {16'd0, pair_sum[16]};
  assign pair_avg = pair_adj[16:1];

  assign len_m1 = (cfg_i.tone_length == 32'd0) ? 32'd0 : cfg_i.tone_length - 32'd1;

  always_comb begin
    phase_acc_d        = phase_acc_q;
    remain_d           = remain_q;
    byte_pos_d         = byte_pos_q;
    fed_d              = fed_q;
    tone_run_d         = tone_run_q;
    wave_run_d         = wave_run_q;
    carrier_d          = carrier_q;
    rd_addr            = AW'(phase_acc_q[31:16]);
    item_d.src         = SRC_HOLD;
    item_d.from_table  = 1'b0;
    item_d.sample      = left_sample_i;
    item_d.tone_done   = 1'b0;
    item_d.wave_done   = 1'b0;
    unique case (command_i)
      CMD_START: begin
        remain_d   = 32'd0;
        byte_pos_d = 32'd0;
        carrier_d  = 1'b1;
        if (!cfg_i.play_mode) begin
          tone_run_d        = 1'b1;
          wave_run_d        = 1'b0;
          rd_addr           = '0;
          item_d.src        = SRC_MAP;
          item_d.from_table = 1'b1;
          phase_acc_d       = cfg_i.phase_step;
          remain_d          = len_m1;
          fed_d             = 32'd1;
        end else begin
          tone_run_d = 1'b0;
          wave_run_d = 1'b1;
          item_d.src = SRC_MID;
          fed_d      = 32'd0;
        end
      end
      CMD_STOP: begin
        tone_run_d = 1'b0;
        wave_run_d = 1'b0;
        remain_d   = 32'd0;
        byte_pos_d = 32'd0;
        carrier_d  = 1'b0;
        item_d.src = SRC_ZERO;
      end
      CMD_WRITE: ;
      CMD_TICK: begin
        if (tone_run_q) begin
          if (remain_q == 32'd0) begin
            tone_run_d       = 1'b0;
            carrier_d        = 1'b0;
            item_d.src       = SRC_ZERO;
            item_d.tone_done = 1'b1;
          end else begin
            item_d.src        = SRC_MAP;
            item_d.from_table = 1'b1;
            phase_acc_d       = phase_acc_q + cfg_i.phase_step;
            remain_d          = remain_q - 32'd1;
            fed_d             = fed_q + 32'd1;
          end
        end else if (wave_run_q) begin
          if ((byte_pos_q >= cfg_i.data_bytes) || (!left_ok_i && stream_end_i)) begin
            wave_run_d       = 1'b0;
            carrier_d        = 1'b0;
            item_d.src       = SRC_ZERO;
            item_d.wave_done = 1'b1;
          end else if (!left_ok_i) begin
            // underrun
            item_d.src = SRC_MID;
          end else begin
            item_d.src = SRC_MAP;
            if (cfg_i.stereo) begin
              if (right_ok_i) begin
                item_d.sample = pair_avg;
              end
              byte_pos_d = byte_pos_q + 32'd4;
            end else begin
              byte_pos_d = byte_pos_q + 32'd2;
            end
            fed_d = fed_q + 32'd1;
          end
        end
      end
      default: ;
    endcase
    item_d.carrier = carrier_d;
    item_d.busy    = tone_run_d || wave_run_d;
    item_d.fed     = fed_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept && (command_i == CMD_WRITE)) begin
      table_mem[wr_addr] <= table_value_i;
    end
    if (accept && (command_i != CMD_WRITE)) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= 32'd0;
      remain_q    <= 32'd0;
      byte_pos_q  <= 32'd0;
      fed_q       <= 32'd0;
      tone_run_q  <= 1'b0;
      wave_run_q  <= 1'b0;
      carrier_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc_q <= phase_acc_d;
        remain_q    <= remain_d;
        byte_pos_q  <= byte_pos_d;
        fed_q       <= fed_d;
        tone_run_q  <= tone_run_d;
        wave_run_q  <= wave_run_d;
        carrier_q   <= carrier_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

endmodule

// ----- rtl/core/pwmf_duty.sv -----
// sample to duty mapping: multiply stage, divide by 65535 and result register
module pwmf_duty import pwmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] pwm_top_i,
  input  logic        s1_valid_i,
  output logic        s1_ready_o,
  input  item_t       item_i,
  input  logic [15:0] table_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_o,
  output logic        carrier_active_o,
  output logic        busy_res_o,
  output logic        tone_done_o,
  output logic        wave_done_o,
  output logic [31:0] fed_count_o
);

  logic        s2_valid_q;
  item_t       s2_item_q;
  logic [31:0] prod_q;
  logic        s2_ready;
  logic        out_ready_int;
  logic        out_valid_q;
  logic [15:0] duty_q, duty_d;
  logic        carrier_q, busy_q, tdone_q, wdone_q;
  logic [31:0] fed_q;

  logic [15:0] sample;
  logic [15:0] offset;
  logic [15:0] quo0;
  logic [16:0] rem0;
  logic [16:0] quo1;
  logic [16:0] rem1;
  logic [16:0] quo;
  logic [15:0] mapped;
  logic [16:0] top_p1;
  logic [15:0] mid;

  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s2_ready      = !s2_valid_q || out_ready_int;
  assign s1_ready_o    = s2_ready;

  // offset binary of the signed sample is s + 32768
  assign sample = item_i.from_table ? table_data_i : item_i.sample;
  assign offset = {~sample[15], sample[14:0]};

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s2_ready) begin
      s2_item_q <= item_i;
      prod_q    <= offset * pwm_top_i;
    end
  end

  // v / 65535: v = q0*65535 + (q0 + lo), then fold the carry and correct once
  assign quo0 = prod_q[31:16];
  assign rem0 = {1'b0, prod_q[15:0]} + {1'b0, quo0};
  assign quo1 = {1'b0, quo0} + {16'd0, rem0[16]};
  assign rem1 = {1'b0, rem0[15:0]} + {16'd0, rem0[16]};
  assign quo  = (rem1 >= 17'd65535) ? quo1 + 17'd1 : quo1;
  assign mapped = (quo > {1'b0, pwm_top_i}) ? pwm_top_i : quo[15:0];

  assign top_p1 = {1'b0, pwm_top_i} + 17'd1;
  assign mid    = top_p1[16:1];

  always_comb begin
    case (s2_item_q.src)
      SRC_MAP:  duty_d = mapped;
      SRC_MID:  duty_d = mid;
      SRC_ZERO: duty_d = 16'd0;
      default:  duty_d = duty_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_ready_int) begin
      carrier_q <= s2_item_q.carrier;
      busy_q    <= s2_item_q.busy;
      tdone_q   <= s2_item_q.tone_done;
      wdone_q   <= s2_item_q.wave_done;
      fed_q     <= s2_item_q.fed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      duty_q      <= 16'd0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_ready_int) begin
        out_valid_q <= s2_valid_q;
      end
      if (s2_valid_q && out_ready_int) begin
        duty_q <= duty_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_o           = duty_q;
  assign carrier_active_o = carrier_q;
  assign busy_res_o       = busy_q;
  assign tone_done_o      = tdone_q;
  assign wave_done_o      = wdone_q;
  assign fed_count_o      = fed_q;

endmodule

// ----- rtl/core/pwmf_checker.sv -----
// port-level checks on the result channel, bound to the top level
module pwmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] duty_o,
  input logic        carrier_active_o,
  input logic        busy_res_o,
  input logic        tone_done_o,
  input logic        wave_done_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_o))
    else $error("stalled result changed");

  // finishing leaves the output silent and idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tone_done_o || wave_done_o) |->
      !busy_res_o && !carrier_active_o && (duty_o == 16'd0))
    else $error("done pulse with output still active");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tone_done_o && wave_done_o))
    else $error("both done pulses at once");

  // carrier off means zero duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !carrier_active_o |-> (duty_o == 16'd0))
    else $error("nonzero duty with carrier off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && busy_res_o |-> carrier_active_o)
    else $error("playback running with carrier off");

endmodule

bind pwm_audio_sample_feeder pwmf_checker u_checker (.*);
